### design/first_fit_page_extent_allocator_macros.svh
// assertion macros used by the allocator top level
`ifndef FIRST_FIT_PAGE_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_EXTENT_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked on the module clock outside reset
`define FFPEA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define FFPEA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/ffpea_pkg.sv
// shared constants, codes and controller/datapath interface types
`default_nettype none
package ffpea_pkg;
   localparam int PAGE_BITS      = 36;
   localparam int MAX_EXTENTS    = 512;
   localparam int PAGES_PER_SLOT = 512;
   localparam int IDX_BITS       = $clog2(MAX_EXTENTS);
   localparam int CNT_BITS       = $clog2(MAX_EXTENTS + 1);
   localparam int WIDE_BITS      = PAGE_BITS + 2;

   localparam logic [1:0] MODE_COUNT = 2'd0;
   localparam logic [1:0] MODE_SLOT  = 2'd1;
   localparam logic [1:0] MODE_FREE  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      PTR_HOLD, PTR_ZERO, PTR_INC, PTR_DEC, PTR_USED, PTR_HIT_INC
   } ptr_op_type;
   typedef enum logic [1:0] {RD_NONE, RD_PTR, RD_NEXT, RD_PREV} rd_op_type;
   typedef enum logic [2:0] {
      WR_NONE, WR_UPDATE, WR_MOVE, WR_SPLIT_LO, WR_SPLIT_HI, WR_APPEND
   } wr_op_type;
   typedef enum logic [1:0] {SUM_HOLD, SUM_SUB_CNT, SUM_SUB_SLOT, SUM_ADD_CNT} sum_op_type;
   typedef enum logic [1:0] {PAGE_HOLD, PAGE_CLEAR, PAGE_START, PAGE_SLOT} page_op_type;
   typedef enum logic [1:0] {USED_HOLD, USED_INC, USED_DEC} used_op_type;

   typedef struct packed {
      logic        load;
      ptr_op_type  ptr_op;
      rd_op_type   rd_op;
      wr_op_type   wr_op;
      sum_op_type  sum_op;
      page_op_type page_op;
      used_op_type used_op;
      logic        set_status;
      logic [1:0]  status;
      logic        latch_hit;
      logic        respond;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       hit;
      logic       gap_nz;
      logic       upd_zero;
      logic       hi_zero;
      logic       last;
      logic       empty;
      logic       full;
      logic       cnt_zero;
      logic       next_valid;
      logic       above_hit;
   } dp_stat_type;
endpackage
`default_nettype wire

### design/ffpea_ctrl.sv
// controller: scan, shift and split sequencing for one transaction
`default_nettype none
module ffpea_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  ffpea_pkg::dp_stat_type    stat,
   output ffpea_pkg::dp_cmd_type     cmd
);
   import ffpea_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CHK, S_END, S_DROP_CHK, S_DROP_WR,
      S_UP_CHK, S_UP_WR, S_SPLIT_LO, S_SPLIT_HI, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   assign busy = busy_ff;

   // next state and datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      busy_in  = busy_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load       = 1'b1;
               cmd.page_op    = PAGE_CLEAR;
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
               cmd.ptr_op     = PTR_ZERO;
               busy_in        = 1'b1;
               state_in       = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!(stat.mode inside {MODE_COUNT, MODE_SLOT, MODE_FREE}) ||
                (stat.mode == MODE_FREE && stat.cnt_zero)) begin
               state_in = S_RESP;
            end else if (stat.empty) begin
               state_in = S_END;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.rd_op = RD_PTR;
            state_in  = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (stat.hit) begin
               case (stat.mode)
                  MODE_COUNT: begin
                     cmd.wr_op   = WR_UPDATE;
                     cmd.sum_op  = SUM_SUB_CNT;
                     cmd.page_op = PAGE_START;
                     state_in    = stat.upd_zero ? S_DROP_CHK : S_RESP;
                  end
                  MODE_SLOT: begin
                     if (!stat.gap_nz) begin
                        cmd.wr_op   = WR_UPDATE;
                        cmd.sum_op  = SUM_SUB_SLOT;
                        cmd.page_op = PAGE_SLOT;
                        state_in    = stat.upd_zero ? S_DROP_CHK : S_RESP;
                     end else if (stat.full) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FULL;
                        state_in       = S_RESP;
                     end else begin
                        cmd.latch_hit = 1'b1;
                        cmd.page_op   = PAGE_SLOT;
                        cmd.ptr_op    = PTR_USED;
                        state_in      = S_UP_CHK;
                     end
                  end
                  default: begin
                     cmd.wr_op  = WR_UPDATE;
                     cmd.sum_op = SUM_ADD_CNT;
                     state_in   = S_RESP;
                  end
               endcase
            end else if (stat.last) begin
               state_in = S_END;
            end else begin
               cmd.ptr_op = PTR_INC;
               state_in   = S_SCAN_RD;
            end
         end
         S_END: begin
            // nothing matched: fail an allocation, append a free unless the table is full
            if (stat.mode != MODE_FREE) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOFIT;
            end else if (stat.full) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_FULL;
            end else begin
               cmd.wr_op   = WR_APPEND;
               cmd.used_op = USED_INC;
               cmd.sum_op  = SUM_ADD_CNT;
            end
            state_in = S_RESP;
         end
         S_DROP_CHK: begin
            if (stat.next_valid) begin
               cmd.rd_op = RD_NEXT;
               state_in  = S_DROP_WR;
            end else begin
               cmd.used_op = USED_DEC;
               state_in    = S_RESP;
            end
         end
         S_DROP_WR: begin
            cmd.wr_op  = WR_MOVE;
            cmd.ptr_op = PTR_INC;
            state_in   = S_DROP_CHK;
         end
         S_UP_CHK: begin
            if (stat.above_hit) begin
               cmd.rd_op = RD_PREV;
               state_in  = S_UP_WR;
            end else begin
               state_in = S_SPLIT_LO;
            end
         end
         S_UP_WR: begin
            cmd.wr_op  = WR_MOVE;
            cmd.ptr_op = PTR_DEC;
            state_in   = S_UP_CHK;
         end
         S_SPLIT_LO: begin
            cmd.wr_op = WR_SPLIT_LO;
            state_in  = S_SPLIT_HI;
         end
         S_SPLIT_HI: begin
            cmd.wr_op   = WR_SPLIT_HI;
            cmd.used_op = USED_INC;
            cmd.sum_op  = SUM_SUB_SLOT;
            cmd.ptr_op  = PTR_HIT_INC;
            state_in    = stat.hi_zero ? S_DROP_CHK : S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            busy_in     = 1'b0;
            state_in    = S_IDLE;
         end
         default: begin
            busy_in  = 1'b0;
            state_in = S_IDLE;
         end
      endcase
   end

   // state and busy registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end
endmodule
`default_nettype wire

### design/ffpea_dp.sv
// datapath: extent table memory, request and result registers, fit arithmetic
`default_nettype none
module ffpea_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [1:0]                        req_mode,
   input  wire logic [ffpea_pkg::PAGE_BITS-1:0]   req_page_number,
   input  wire logic [ffpea_pkg::PAGE_BITS-1:0]   req_page_count,
   input  ffpea_pkg::dp_cmd_type                  cmd,
   output ffpea_pkg::dp_stat_type                 stat,
   output logic                                   rsp_valid,
   output logic [ffpea_pkg::PAGE_BITS-1:0]        rsp_alloc_page,
   output logic [1:0]                             rsp_status,
   output logic [ffpea_pkg::PAGE_BITS-1:0]        rsp_free_total,
   output logic [ffpea_pkg::CNT_BITS-1:0]         rsp_extent_total
);
   import ffpea_pkg::*;

   localparam logic [WIDE_BITS-1:0] SLOT_W = WIDE_BITS'(PAGES_PER_SLOT);
   localparam logic [PAGE_BITS-1:0] SLOT_P = PAGE_BITS'(PAGES_PER_SLOT);

   logic [2*PAGE_BITS-1:0] ext_mem_ff [MAX_EXTENTS];
   logic [2*PAGE_BITS-1:0] rdata_ff;
   logic [1:0]             mode_ff;
   logic [PAGE_BITS-1:0]   pn_ff, cnt_ff;
   logic [CNT_BITS-1:0]    ptr_ff, ptr_in, hit_ff, used_ff, used_in;
   logic [PAGE_BITS-1:0]   sum_ff, sum_in, page_ff;
   logic [1:0]             status_ff;
   logic                   rsp_valid_ff;
   logic [PAGE_BITS-1:0]   lat_start_ff, lat_gap_ff, lat_sstart_ff, lat_slen_ff;

   logic [CNT_BITS-1:0]    ptr_inc, ptr_dec, hit_inc;
   logic [IDX_BITS-1:0]    rd_addr, wr_addr;
   logic [2*PAGE_BITS-1:0] wr_data;
   logic                   wr_en;
   logic [PAGE_BITS-1:0]   ent_start, ent_len;
   logic [WIDE_BITS-1:0]   base_w, b_w;
   logic                   slot_fit, count_fit, m_end, m_tail;
   logic [PAGE_BITS-1:0]   gap, slot_start, slot_len, end_page, tail_page;
   logic [PAGE_BITS-1:0]   upd_start, upd_len;

   assign ptr_inc = ptr_ff + CNT_BITS'(1);
   assign ptr_dec = ptr_ff - CNT_BITS'(1);
   assign hit_inc = hit_ff + CNT_BITS'(1);

   assign ent_start = rdata_ff[2*PAGE_BITS-1:PAGE_BITS];
   assign ent_len   = rdata_ff[PAGE_BITS-1:0];

   // aligned slot inside the current extent
   assign base_w     = {2'b00, ent_start};
   assign b_w        = (base_w + SLOT_W - WIDE_BITS'(1)) & ~(SLOT_W - WIDE_BITS'(1));
   assign slot_fit   = (base_w + {2'b00, ent_len}) >= (b_w + SLOT_W);
   assign gap        = PAGE_BITS'(b_w - base_w);
   assign slot_start = PAGE_BITS'(b_w + SLOT_W);
   assign slot_len   = ent_len - gap - SLOT_P;

   // count fit and free adjacency
   assign count_fit = ent_len >= cnt_ff;
   assign end_page  = pn_ff + cnt_ff;
   assign tail_page = ent_start + ent_len;
   assign m_end     = ent_start == end_page;
   assign m_tail    = tail_page == pn_ff;

   // updated entry for the matching mode
   always_comb begin
      case (mode_ff)
         MODE_COUNT: begin
            upd_start = ent_start + cnt_ff;
            upd_len   = ent_len - cnt_ff;
         end
         MODE_SLOT: begin
            upd_start = slot_start;
            upd_len   = slot_len;
         end
         default: begin
            upd_start = m_end ? pn_ff : ent_start;
            upd_len   = ent_len + cnt_ff;
         end
      endcase
   end

   // status toward the controller
   always_comb begin
      stat.mode = mode_ff;
      case (mode_ff)
         MODE_COUNT: stat.hit = count_fit;
         MODE_SLOT:  stat.hit = slot_fit;
         default:    stat.hit = m_end | m_tail;
      endcase
      stat.gap_nz     = gap != '0;
      stat.upd_zero   = upd_len == '0;
      stat.hi_zero    = lat_slen_ff == '0;
      stat.last       = ptr_inc == used_ff;
      stat.empty      = used_ff == '0;
      stat.full       = used_ff == CNT_BITS'(MAX_EXTENTS);
      stat.cnt_zero   = cnt_ff == '0;
      stat.next_valid = ptr_inc < used_ff;
      stat.above_hit  = ptr_ff > hit_ff;
   end

   // read address select
   always_comb begin
      case (cmd.rd_op)
         RD_NEXT: rd_addr = ptr_inc[IDX_BITS-1:0];
         RD_PREV: rd_addr = ptr_dec[IDX_BITS-1:0];
         default: rd_addr = ptr_ff[IDX_BITS-1:0];
      endcase
   end

   // write address and data select
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = ptr_ff[IDX_BITS-1:0];
      wr_data = {upd_start, upd_len};
      case (cmd.wr_op)
         WR_UPDATE: wr_data = {upd_start, upd_len};
         WR_MOVE:   wr_data = rdata_ff;
         WR_SPLIT_LO: begin
            wr_addr = hit_ff[IDX_BITS-1:0];
            wr_data = {lat_start_ff, lat_gap_ff};
         end
         WR_SPLIT_HI: begin
            wr_addr = hit_inc[IDX_BITS-1:0];
            wr_data = {lat_sstart_ff, lat_slen_ff};
         end
         WR_APPEND: begin
            wr_addr = used_ff[IDX_BITS-1:0];
            wr_data = {pn_ff, cnt_ff};
         end
         default: wr_en = 1'b0;
      endcase
   end

   // extent table memory
   always_ff @(posedge clock) begin
      if (cmd.rd_op != RD_NONE) begin
         rdata_ff <= ext_mem_ff[rd_addr];
      end
      if (wr_en) begin
         ext_mem_ff[wr_addr] <= wr_data;
      end
   end

   // pointer, count and sum next values
   always_comb begin
      case (cmd.ptr_op)
         PTR_ZERO:    ptr_in = '0;
         PTR_INC:     ptr_in = ptr_inc;
         PTR_DEC:     ptr_in = ptr_dec;
         PTR_USED:    ptr_in = used_ff;
         PTR_HIT_INC: ptr_in = hit_inc;
         default:     ptr_in = ptr_ff;
      endcase
      case (cmd.used_op)
         USED_INC: used_in = used_ff + CNT_BITS'(1);
         USED_DEC: used_in = used_ff - CNT_BITS'(1);
         default:  used_in = used_ff;
      endcase
      case (cmd.sum_op)
         SUM_SUB_CNT:  sum_in = sum_ff - cnt_ff;
         SUM_SUB_SLOT: sum_in = sum_ff - SLOT_P;
         SUM_ADD_CNT:  sum_in = sum_ff + cnt_ff;
         default:      sum_in = sum_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         mode_ff <= req_mode;
         pn_ff   <= req_page_number;
         cnt_ff  <= req_page_count;
      end
      if (cmd.latch_hit) begin
         hit_ff        <= ptr_ff;
         lat_start_ff  <= ent_start;
         lat_gap_ff    <= gap;
         lat_sstart_ff <= slot_start;
         lat_slen_ff   <= slot_len;
      end
      case (cmd.page_op)
         PAGE_CLEAR: page_ff <= '0;
         PAGE_START: page_ff <= ent_start;
         PAGE_SLOT:  page_ff <= PAGE_BITS'(b_w);
         default:    page_ff <= page_ff;
      endcase
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_alloc_page   = page_ff;
   assign rsp_status       = status_ff;
   assign rsp_free_total   = sum_ff;
   assign rsp_extent_total = used_ff;
endmodule
`default_nettype wire

### design/first_fit_page_extent_allocator.sv
// top level of the first-fit page extent allocator
//
// Request channel: present req_mode, req_page_number and req_page_count with
// start high; the transaction is taken at the clock edge where busy is low.
// busy stays high until the result is issued, and one request is worked on
// at a time. Each transaction gives exactly one result, shown for one cycle
// with rsp_valid high; the receiver cannot stall it.
// A scan reads one table entry at a time through a read state and a check
// state (one memory read port with registered data), so a request takes
// longer the later the hit, longest for a full scan. Removing an emptied
// extent or opening a gap for a split moves the entries above it one at a
// time, each with a read and a write state.
// The next request may be started in the cycle the result is shown.
// Reset (synchronous) empties the table and clears the free-page total at
// once; no clearing pass runs, entries are written before they are read.
`default_nettype none
`include "first_fit_page_extent_allocator_macros.svh"
module first_fit_page_extent_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_mode,
   input  wire logic [ffpea_pkg::PAGE_BITS-1:0]   req_page_number,
   input  wire logic [ffpea_pkg::PAGE_BITS-1:0]   req_page_count,
   output logic                                   rsp_valid,
   output logic [ffpea_pkg::PAGE_BITS-1:0]        rsp_alloc_page,
   output logic [1:0]                             rsp_status,
   output logic [ffpea_pkg::PAGE_BITS-1:0]        rsp_free_total,
   output logic [ffpea_pkg::CNT_BITS-1:0]         rsp_extent_total
);
   import ffpea_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencing
   ffpea_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // table and arithmetic
   ffpea_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_mode         (req_mode),
      .req_page_number  (req_page_number),
      .req_page_count   (req_page_count),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_alloc_page   (rsp_alloc_page),
      .rsp_status       (rsp_status),
      .rsp_free_total   (rsp_free_total),
      .rsp_extent_total (rsp_extent_total)
   );

   // checks
   `FFPEA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
   `FFPEA_ASSERT_IMP(a_rsp_idle, rsp_valid, !busy)
   `FFPEA_ASSERT_IMP(a_fail_zero, rsp_valid && rsp_status != ST_OK, rsp_alloc_page == '0)
   `FFPEA_ASSERT_IMP(a_table_bound, rsp_valid,
      rsp_extent_total <= CNT_BITS'(MAX_EXTENTS))
endmodule
`default_nettype wire

### test/first_fit_page_extent_allocator_tb.sv
// self-checking testbench for the first-fit page extent allocator
`default_nettype none
module first_fit_page_extent_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ffpea_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [PAGE_BITS-1:0] PAGE_ONES = '1;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [PAGE_BITS-1:0] alloc_page;
      logic [1:0]           status;
      logic [PAGE_BITS-1:0] free_total;
      logic [CNT_BITS-1:0]  extent_total;
   } alloc_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [1:0] req_mode = MODE_COUNT;
   logic [PAGE_BITS-1:0] req_page_number = '0;
   logic [PAGE_BITS-1:0] req_page_count = '0;
   logic busy, rsp_valid;
   logic [PAGE_BITS-1:0] rsp_alloc_page, rsp_free_total;
   logic [1:0] rsp_status;
   logic [CNT_BITS-1:0] rsp_extent_total;

   // shadow of the free extent table
   bit [PAGE_BITS-1:0] ext_base [MAX_EXTENTS];
   bit [PAGE_BITS-1:0] ext_len [MAX_EXTENTS];
   int unsigned ext_count = 0;
   bit [PAGE_BITS-1:0] pages_free = '0;

   alloc_rsp_type pending_rsp[$];
   int errors = 0;
   int requests_sent = 0;
   int rsp_checked = 0;
   int idle_pct = 0;
   int full_hits = 0;
   int nofit_hits = 0;

   first_fit_page_extent_allocator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_page_number(req_page_number),
      .req_page_count(req_page_count), .rsp_valid(rsp_valid),
      .rsp_alloc_page(rsp_alloc_page), .rsp_status(rsp_status),
      .rsp_free_total(rsp_free_total), .rsp_extent_total(rsp_extent_total)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // remove one entry and close the hole
   function automatic void remove_extent(int unsigned k);
      for (int unsigned j = k; j + 1 < ext_count; j++) begin
         ext_base[j] = ext_base[j + 1];
         ext_len[j] = ext_len[j + 1];
      end
      ext_count--;
   endfunction

   // first-fit allocation of a page count
   function automatic logic [1:0] take_pages(bit [PAGE_BITS-1:0] cnt,
                                             output bit [PAGE_BITS-1:0] page);
      page = '0;
      for (int unsigned i = 0; i < ext_count; i++) begin
         if (ext_len[i] >= cnt) begin
            page = ext_base[i];
            ext_base[i] = ext_base[i] + cnt;
            ext_len[i] = ext_len[i] - cnt;
            if (ext_len[i] == 0) remove_extent(i);
            pages_free = pages_free - cnt;
            return ST_OK;
         end
      end
      return ST_NOFIT;
   endfunction

   // first-fit allocation of one aligned slot, splitting where needed
   function automatic logic [1:0] take_aligned_slot(output bit [PAGE_BITS-1:0] page);
      bit [63:0] slot, base, len, aligned, gap;
      int unsigned upper;
      slot = 64'(PAGES_PER_SLOT);
      page = '0;
      for (int unsigned i = 0; i < ext_count; i++) begin
         base = 64'(ext_base[i]);
         len = 64'(ext_len[i]);
         aligned = ((base + slot - 1) / slot) * slot;
         if (base + len < aligned + slot) continue;
         gap = aligned - base;
         if (gap != 0) begin
            if (ext_count >= MAX_EXTENTS) return ST_FULL;
            for (int unsigned j = ext_count; j > i; j--) begin
               ext_base[j] = ext_base[j - 1];
               ext_len[j] = ext_len[j - 1];
            end
            ext_count++;
            ext_len[i] = gap[PAGE_BITS-1:0];
            upper = i + 1;
         end else begin
            upper = i;
         end
         ext_base[upper] = PAGE_BITS'(aligned + slot);
         ext_len[upper] = PAGE_BITS'(len - gap - slot);
         if (ext_len[upper] == 0) remove_extent(upper);
         pages_free = pages_free - PAGE_BITS'(slot);
         page = aligned[PAGE_BITS-1:0];
         return ST_OK;
      end
      return ST_NOFIT;
   endfunction

   // return a run, merging with the first touching extent or appending
   function automatic logic [1:0] return_run(bit [PAGE_BITS-1:0] base,
                                             bit [PAGE_BITS-1:0] cnt);
      bit [PAGE_BITS-1:0] run_end;
      int unsigned i;
      run_end = base + cnt;
      if (cnt == 0) return ST_OK;
      for (i = 0; i < ext_count; i++) begin
         if (ext_base[i] == run_end) begin
            ext_base[i] = base;
            break;
         end
         if (PAGE_BITS'(ext_base[i] + ext_len[i]) == base) break;
      end
      if (i == ext_count) begin
         if (ext_count >= MAX_EXTENTS) return ST_FULL;
         ext_count++;
         ext_base[i] = base;
         ext_len[i] = '0;
      end
      ext_len[i] = ext_len[i] + cnt;
      pages_free = pages_free + cnt;
      return ST_OK;
   endfunction

   function automatic alloc_rsp_type predict_alloc(logic [1:0] m,
                                                   bit [PAGE_BITS-1:0] pn,
                                                   bit [PAGE_BITS-1:0] pc);
      alloc_rsp_type r;
      bit [PAGE_BITS-1:0] page;
      page = '0;
      r.status = ST_OK;
      case (m)
         MODE_COUNT: r.status = take_pages(pc, page);
         MODE_SLOT:  r.status = take_aligned_slot(page);
         MODE_FREE:  r.status = return_run(pn, pc);
         default:    r.status = ST_OK;
      endcase
      if (r.status == ST_FULL) full_hits++;
      if (r.status == ST_NOFIT) nofit_hits++;
      r.alloc_page = (r.status == ST_OK) ? page : '0;
      r.free_total = pages_free;
      r.extent_total = CNT_BITS'(ext_count);
      return r;
   endfunction

   // one transaction; returns at the accepting edge with start still high, or later after a random gap with start low
   task automatic send_request(logic [1:0] m, logic [PAGE_BITS-1:0] pn,
                               logic [PAGE_BITS-1:0] pc);
      req_mode <= m;
      req_page_number <= pn;
      req_page_count <= pc;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_alloc(m, pn, pc));
      requests_sent++;
      // random gap before the next transaction
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 60 : 6)) @(posedge clock);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      alloc_rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result, alloc_page %h status %0d", $time,
                     rsp_alloc_page, rsp_status);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            rsp_checked++;
            if (rsp_alloc_page !== e.alloc_page) begin
               $display("%0t: alloc_page expected %h actual %h", $time, e.alloc_page,
                        rsp_alloc_page);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_free_total !== e.free_total) begin
               $display("%0t: free_total expected %h actual %h", $time, e.free_total,
                        rsp_free_total);
               errors++;
            end
            if (rsp_extent_total !== e.extent_total) begin
               $display("%0t: extent_total expected %0d actual %0d", $time,
                        e.extent_total, rsp_extent_total);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction and no result
   always @(posedge clock) begin
      int quiet;
      if (reset || (start && !busy) || rsp_valid) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
         $display("watchdog expired at %0t", $time);
         $display("first_fit_page_extent_allocator_tb: FAIL");
         $finish;
      end
   end

   // extremes, every mode and the corner cases on a small table
   task automatic test_directed();
      send_request(MODE_UNUSED, PAGE_ONES, PAGE_ONES);
      send_request(MODE_COUNT, '0, '0);
      send_request(MODE_SLOT, '0, '0);
      send_request(MODE_FREE, 36'h5, '0);
      send_request(MODE_FREE, 36'h300, 36'h500);
      send_request(MODE_SLOT, '0, '0);
      send_request(MODE_SLOT, '0, '0);
      send_request(MODE_COUNT, PAGE_ONES, '0);
      send_request(MODE_FREE, 36'h200, 36'h100);
      send_request(MODE_FREE, 36'h400, 36'h10);
      send_request(MODE_COUNT, '0, 36'h10);
      send_request(MODE_COUNT, '0, 36'h1000);
      send_request(MODE_FREE, PAGE_ONES, 36'h1);
      send_request(MODE_FREE, '0, PAGE_ONES);
      send_request(MODE_SLOT, '0, '0);
      send_request(MODE_COUNT, '0, PAGE_ONES);
      send_request(MODE_COUNT, '0, 36'h1);
      send_request(MODE_FREE, 36'h8_0000_0000, 36'h7_FFFF_FFFF);
      send_request(MODE_COUNT, 36'hA_AAAA_AAAA, 36'h5_5555_5555);
   endtask

   task automatic send_random();
      int unsigned pick;
      logic [1:0] m;
      logic [PAGE_BITS-1:0] pn, pc;
      pick = $urandom_range(99);
      pn = PAGE_BITS'($urandom_range(8191));
      pc = ($urandom_range(3) == 0) ? PAGE_BITS'($urandom_range(2048))
                                    : PAGE_BITS'($urandom_range(64));
      if (pick < 42) m = MODE_FREE;
      else if (pick < 72) m = MODE_COUNT;
      else if (pick < 92) m = MODE_SLOT;
      else if (pick < 96) m = MODE_UNUSED;
      else begin
         // full-width noise
         m = 2'($urandom_range(3));
         pn = PAGE_BITS'({$urandom(), $urandom()});
         pc = ($urandom_range(1) == 0) ? PAGE_BITS'({$urandom(), $urandom()})
                                       : PAGE_BITS'($urandom_range(8));
      end
      if ($urandom_range(19) == 0) pc = '0;
      send_request(m, pn, pc);
   endtask

   // random mix in a small page window so merges and splits are frequent
   task automatic test_random_mix(int count);
      for (int n = 0; n < count; n++) begin
         case ((n * 4) / count)
            0: idle_pct = 0;
            1: idle_pct = 68;
            2: idle_pct = 22;
            default: idle_pct = (n % 40 < 20) ? 0 : 68;
         endcase
         send_random();
      end
   endtask

   // empty the table, then fill it to capacity and hit the table-full paths
   task automatic test_full_table();
      idle_pct = 10;
      while (ext_count != 0) send_request(MODE_COUNT, '0, ext_len[0]);
      send_request(MODE_FREE, 36'h100, 36'h1000);
      for (int k = 0; k < MAX_EXTENTS - 1; k++)
         send_request(MODE_FREE, 36'h10_0000 + 4 * k, 36'h2);
      send_request(MODE_SLOT, '0, '0);
      send_request(MODE_FREE, 36'h20_0000, 36'h3);
      send_request(MODE_FREE, 36'h10_0002, 36'h1);
      send_request(MODE_FREE, 36'h10_0000 + 4 * (MAX_EXTENTS - 2) - 1, 36'h1);
      send_request(MODE_COUNT, '0, 36'h3);
      send_request(MODE_SLOT, '0, '0);
      send_request(MODE_SLOT, '0, '0);
      // random traffic around a full table
      for (int n = 0; n < 10; n++) begin
         if ($urandom_range(1) == 0)
            send_request(MODE_FREE, 36'h30_0000 + 8 * $urandom_range(64),
                         PAGE_BITS'($urandom_range(1, 3)));
         else
            send_random();
      end
   endtask

   initial begin
      int drain;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mix(30);
      test_full_table();
      start <= 1'b0;
      drain = 0;
      while (pending_rsp.size() != 0 && drain < IDLE_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      $display("%0d requests sent, %0d results checked, %0d without fit, %0d table full",
               requests_sent, rsp_checked, nofit_hits, full_hits);
      $display("covered all modes, merges at both ends, slot splits and a full table");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("first_fit_page_extent_allocator_tb: PASS");
      end else begin
         $display("first_fit_page_extent_allocator_tb: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
